// ----- rtl/affine_texture_sampler_unit_assert.svh -----
// Assertion macros for the affine texture sampler unit.
`ifndef AFFINE_TEXTURE_SAMPLER_UNIT_ASSERT_SVH
`define AFFINE_TEXTURE_SAMPLER_UNIT_ASSERT_SVH

// Check that cond, sampled at an edge, implies result after the delay
// given by n. The check is off while rst is high.
`define ATS_ASSERT_AFTER(label, clk, rst, cond, n, result, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##n (result)) \
      else $error(msg);

// Check that cond implies result at the same edge. The check is off while rst is high.
`define ATS_ASSERT_NOW(label, clk, rst, cond, result, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (result)) \
      else $error(msg);

`endif

// ----- rtl/ats_pkg.sv -----
// Shared constants and types for the affine texture sampler.
`timescale 1ns / 1ps

package ats_pkg;

   localparam int TEX_W       = 16;
   localparam int TEX_H       = 16;
   localparam int COEF_FRAC   = 10;
   localparam int COL_BITS    = $clog2(TEX_W);
   localparam int ROW_BITS    = $clog2(TEX_H);

   localparam int STORE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int TEXEL_W     = 8;
   localparam int COEF_W      = 18;
   localparam int PIX_W       = 11;
   localparam int CENTER_W    = 8;
   localparam int DELTA_W     = PIX_W + 1;
   localparam int PROD_W      = COEF_W + DELTA_W;
   localparam int SUM_W       = PROD_W + 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = COEF_W;

   localparam logic KIND_RENDER = 1'b0;
   localparam logic KIND_WRITE  = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEF_COS        = 3'd0,
      CSR_COEF_SIN        = 3'd1,
      CSR_SCREEN_CENTER_X = 3'd2,
      CSR_SCREEN_CENTER_Y = 3'd3,
      CSR_TEX_CENTER_X    = 3'd4,
      CSR_TEX_CENTER_Y    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_cos;
      logic signed [COEF_W-1:0] coef_sin;
      logic [PIX_W-1:0]         screen_center_x;
      logic [PIX_W-1:0]         screen_center_y;
      logic [CENTER_W-1:0]      tex_center_x;
      logic [CENTER_W-1:0]      tex_center_y;
   } ats_cfg_type;

   typedef struct packed {
      logic               valid;
      logic               write;
      logic [ADDR_W-1:0]  addr;
      logic [TEXEL_W-1:0] data;
   } mem_op_type;

endpackage

// ----- rtl/ats_coord_pipe.sv -----
// Coordinate pipeline: screen pixel to texture store address, four stages.
`timescale 1ns / 1ps

module ats_coord_pipe import ats_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               kind,
   input  logic [PIX_W-1:0]   pixel_x,
   input  logic [PIX_W-1:0]   pixel_y,
   input  logic [ADDR_W-1:0]  texel_addr,
   input  logic [TEXEL_W-1:0] texel_value,
   input  ats_cfg_type        cfg,
   output mem_op_type         mem_op
);

   // Truncate toward zero (the caller adds the half), keep the low bits (true modulo).
   function automatic logic [CENTER_W-1:0] wrap_coord(input logic signed [SUM_W-1:0] t);
      logic signed [SUM_W-1:0] fl;
      logic                    corr;
      fl   = t >>> (COEF_FRAC + 1);
      corr = t[SUM_W-1] & (|t[COEF_FRAC:0]);
      return fl[CENTER_W-1:0] + {{(CENTER_W-1){1'b0}}, corr};
   endfunction

   // stage A: offsets from screen center
   logic                      a_valid_ff, a_valid_in;
   logic                      a_write_ff;
   logic signed [DELTA_W-1:0] a_dx_ff, a_dx_in;
   logic signed [DELTA_W-1:0] a_dy_ff, a_dy_in;
   logic [ADDR_W-1:0]         a_addr_ff;
   logic [TEXEL_W-1:0]        a_data_ff;

   // stage B: products
   logic                     b_valid_ff;
   logic                     b_write_ff;
   logic signed [PROD_W-1:0] b_adx_ff, b_adx_in;
   logic signed [PROD_W-1:0] b_bdy_ff, b_bdy_in;
   logic signed [PROD_W-1:0] b_bdx_ff, b_bdx_in;
   logic signed [PROD_W-1:0] b_ady_ff, b_ady_in;
   logic [ADDR_W-1:0]        b_addr_ff;
   logic [TEXEL_W-1:0]       b_data_ff;

   // stage C: texture coordinates in half-texel-fraction units
   logic                    c_valid_ff;
   logic                    c_write_ff;
   logic signed [SUM_W-1:0] c_tu_ff, c_tu_in;
   logic signed [SUM_W-1:0] c_tv_ff, c_tv_in;
   logic [ADDR_W-1:0]       c_addr_ff;
   logic [TEXEL_W-1:0]      c_data_ff;

   // stage D: store access
   mem_op_type op_ff, op_in;

   logic signed [SUM_W-1:0]      ext_adx, ext_bdy, ext_bdx, ext_ady;
   logic [SUM_W-1:0]             ctr_u, ctr_v, half;
   logic [CENTER_W-1:0]          col_wide, row_wide;
   logic [ROW_BITS+COL_BITS-1:0] row_col;

   always_comb begin
      a_valid_in = accept;
      a_dx_in    = $signed({1'b0, pixel_x} - {1'b0, cfg.screen_center_x});
      a_dy_in    = $signed({1'b0, pixel_y} - {1'b0, cfg.screen_center_y});

      b_adx_in = cfg.coef_cos * a_dx_ff;
      b_bdy_in = cfg.coef_sin * a_dy_ff;
      b_bdx_in = cfg.coef_sin * a_dx_ff;
      b_ady_in = cfg.coef_cos * a_dy_ff;

      ext_adx = SUM_W'(b_adx_ff);
      ext_bdy = SUM_W'(b_bdy_ff);
      ext_bdx = SUM_W'(b_bdx_ff);
      ext_ady = SUM_W'(b_ady_ff);
      half    = SUM_W'(1) << COEF_FRAC;
      ctr_u   = SUM_W'({cfg.tex_center_x, {(COEF_FRAC + 1){1'b0}}}) + half;
      ctr_v   = SUM_W'({cfg.tex_center_y, {(COEF_FRAC + 1){1'b0}}}) + half;
      c_tu_in = ext_adx + (ext_bdy <<< 1) + $signed(ctr_u);
      c_tv_in = (ext_ady <<< 1) - ext_bdx + $signed(ctr_v);

      col_wide = wrap_coord(c_tu_ff);
      row_wide = wrap_coord(c_tv_ff);
      row_col  = {row_wide[ROW_BITS-1:0], col_wide[COL_BITS-1:0]};

      op_in.valid = c_valid_ff;
      op_in.write = c_write_ff;
      op_in.data  = c_data_ff;
      op_in.addr  = c_write_ff ? c_addr_ff : ADDR_W'(row_col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
         op_ff.valid    <= 1'b0;
      end else begin
         a_valid_ff     <= a_valid_in;
         b_valid_ff     <= a_valid_ff;
         c_valid_ff     <= b_valid_ff;
         op_ff          <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      a_write_ff <= (kind == KIND_WRITE);
      a_dx_ff    <= a_dx_in;
      a_dy_ff    <= a_dy_in;
      a_addr_ff  <= texel_addr;
      a_data_ff  <= texel_value;

      b_write_ff <= a_write_ff;
      b_adx_ff   <= b_adx_in;
      b_bdy_ff   <= b_bdy_in;
      b_bdx_ff   <= b_bdx_in;
      b_ady_ff   <= b_ady_in;
      b_addr_ff  <= a_addr_ff;
      b_data_ff  <= a_data_ff;

      c_write_ff <= b_write_ff;
      c_tu_ff    <= c_tu_in;
      c_tv_ff    <= c_tv_in;
      c_addr_ff  <= b_addr_ff;
      c_data_ff  <= b_data_ff;
   end

   assign mem_op = op_ff;

endmodule

// ----- rtl/ats_texture_ram.sv -----
// Texture store: one write or one registered read per cycle.
`timescale 1ns / 1ps

module ats_texture_ram import ats_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  mem_op_type         mem_op,
   output logic               rd_valid,
   output logic [TEXEL_W-1:0] rd_data
);

   logic [TEXEL_W-1:0] store_ff [STORE_DEPTH];
   logic               rd_valid_ff;
   logic [TEXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_op.valid && mem_op.write) begin
         store_ff[mem_op.addr] <= mem_op.data;
      end
      rd_data_ff <= store_ff[mem_op.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= mem_op.valid && !mem_op.write;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_data  = rd_data_ff;

endmodule

// ----- rtl/affine_texture_sampler_unit.sv -----
// Top level of the rotate-and-zoom affine texture sampler.
`timescale 1ns / 1ps
`include "affine_texture_sampler_unit_assert.svh"

// Rotate-and-zoom texture sampler. Drive start with req_kind = 1 to store
// req_texel_value at req_texel_addr, or with req_kind = 0 to render the
// screen pixel (req_pixel_x, req_pixel_y); busy is low except during reset,
// so a transaction can be issued every clock. Each render transaction
// returns one texel on rsp_texel_out with rsp_strobe high for one cycle,
// after the pipeline and the store read; write transactions return nothing.
// There is no way to stall the response side, so capture the strobe when
// it comes. Transactions complete in issue order, and a texel write takes
// effect for every render issued after it. Throughput is one transaction
// per clock, set by the single port of the texture store, which each
// transaction uses once (write or read) in the last pipeline stage. The
// pipeline has four stages ahead of the store: offset from the screen
// center, the four coefficient products, the two coordinate sums, and
// rounding and wrapping into a store address. Load the csr_ registers only
// while no transaction is in flight; the pipeline reads them live. A
// texel that was never written reads back as an unknown value.

module affine_texture_sampler_unit import ats_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_kind,
   input  logic [PIX_W-1:0]       req_pixel_x,
   input  logic [PIX_W-1:0]       req_pixel_y,
   input  logic [ADDR_W-1:0]      req_texel_addr,
   input  logic [TEXEL_W-1:0]     req_texel_value,
   output logic                   rsp_strobe,
   output logic [TEXEL_W-1:0]     rsp_texel_out,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ats_cfg_type cfg_ff, cfg_in;
   mem_op_type  mem_op;
   logic        accept;

   // Take a transaction on any cycle outside reset.
   assign busy   = reset;
   assign accept = start && !busy;

   // Register writes; an index past the list leaves everything alone.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COEF_COS:        cfg_in.coef_cos        = $signed(csr_wdata[COEF_W-1:0]);
            CSR_COEF_SIN:        cfg_in.coef_sin        = $signed(csr_wdata[COEF_W-1:0]);
            CSR_SCREEN_CENTER_X: cfg_in.screen_center_x = csr_wdata[PIX_W-1:0];
            CSR_SCREEN_CENTER_Y: cfg_in.screen_center_y = csr_wdata[PIX_W-1:0];
            CSR_TEX_CENTER_X:    cfg_in.tex_center_x    = csr_wdata[CENTER_W-1:0];
            CSR_TEX_CENTER_Y:    cfg_in.tex_center_y    = csr_wdata[CENTER_W-1:0];
            default:             cfg_in                 = cfg_ff;
         endcase
      end
   end

   // Reset to unit zoom, no rotation, texture center at (8, 8).
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_cos        <= COEF_W'(1 << COEF_FRAC);
         cfg_ff.coef_sin        <= '0;
         cfg_ff.screen_center_x <= '0;
         cfg_ff.screen_center_y <= '0;
         cfg_ff.tex_center_x    <= CENTER_W'(8);
         cfg_ff.tex_center_y    <= CENTER_W'(8);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Advance each transaction through the coordinate stages.
   ats_coord_pipe u_coord_pipe (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .kind        (req_kind),
      .pixel_x     (req_pixel_x),
      .pixel_y     (req_pixel_y),
      .texel_addr  (req_texel_addr),
      .texel_value (req_texel_value),
      .cfg         (cfg_ff),
      .mem_op      (mem_op)
   );

   // Write or read the texture store; a read drives the response strobe.
   ats_texture_ram u_texture_ram (
      .clock    (clock),
      .reset    (reset),
      .mem_op   (mem_op),
      .rd_valid (rsp_strobe),
      .rd_data  (rsp_texel_out)
   );

   // A render transaction is answered with a response strobe.
   `ATS_ASSERT_AFTER(a_render_latency, clock, reset, accept && req_kind == KIND_RENDER, 5, rsp_strobe, "render transaction without response")
   // A texel write never produces a response.
   `ATS_ASSERT_AFTER(a_write_silent, clock, reset, accept && req_kind == KIND_WRITE, 5, !rsp_strobe, "write transaction produced a response")
   // A store access in flight always came from an accepted transaction.
   `ATS_ASSERT_NOW(a_op_origin, clock, reset, mem_op.valid, $past(accept, 4), "store access without a transaction")

endmodule

// ----- sim/tb_affine_texture_sampler_unit.sv -----
// Self-checking regression bench for the affine texture sampler unit.
`timescale 1ns / 1ps

module tb_affine_texture_sampler_unit;
   import ats_pkg::*;

   // Render transactions come back through the pipeline and the store; wait
   // out PIPE_DRAIN before touching the registers so the pipeline is empty.
   localparam int PIPE_DRAIN  = 8;
   localparam int DRAIN_LIMIT = 200;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 40;

   // Indexes past the register list: the block must drop these writes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_kind = KIND_RENDER;
   logic [PIX_W-1:0]       req_pixel_x = '0;
   logic [PIX_W-1:0]       req_pixel_y = '0;
   logic [ADDR_W-1:0]      req_texel_addr = '0;
   logic [TEXEL_W-1:0]     req_texel_value = '0;
   logic                   rsp_strobe;
   logic [TEXEL_W-1:0]     rsp_texel_out;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Mirror of the block: register copy, texture copy, and the texels that
   // render transactions still owe us, oldest first.
   ats_cfg_type        shadow_cfg;
   logic [TEXEL_W-1:0] texture_mirror [STORE_DEPTH];
   logic [TEXEL_W-1:0] pending_texels [$];

   int mismatch_count  = 0;
   int cycle_count     = 0;
   int sender_idle_pct = 0;

   affine_texture_sampler_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_texel_addr  (req_texel_addr),
      .req_texel_value (req_texel_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_texel_out   (rsp_texel_out),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // Hard stop in case the block hangs or drops its strobe for good.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("affine_texture_sampler_unit regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Texel address prediction
   // ---------------------------------------------------------------------

   // Add one half, truncate toward zero, then take a true modulo so that
   // negative coordinates wrap back into the texture. t is in units of
   // 2^-(COEF_FRAC+1) and already carries the texture center.
   function automatic longint texel_index_of(longint t, longint size);
      longint q;
      longint r;
      t = t + (longint'(1) << COEF_FRAC);
      q = t / (longint'(1) << (COEF_FRAC + 1));
      r = q % size;
      if (r < 0) begin
         r = r + size;
      end
      return r;
   endfunction

   // Rotate and scale the screen offset into texture space. Working in half
   // units keeps dx/2 exact, so a*dx stands for a*dx/2 and 2*b*dy for b*dy.
   function automatic logic [ADDR_W-1:0] render_addr_for(logic [PIX_W-1:0] px,
                                                         logic [PIX_W-1:0] py);
      longint a;
      longint b;
      longint dx;
      longint dy;
      longint tu;
      longint tv;
      longint col;
      longint row;
      a  = longint'($signed(shadow_cfg.coef_cos));
      b  = longint'($signed(shadow_cfg.coef_sin));
      dx = longint'(px) - longint'(shadow_cfg.screen_center_x);
      dy = longint'(py) - longint'(shadow_cfg.screen_center_y);
      tu = a * dx + 2 * b * dy + (longint'(shadow_cfg.tex_center_x) << (COEF_FRAC + 1));
      tv = -b * dx + 2 * a * dy + (longint'(shadow_cfg.tex_center_y) << (COEF_FRAC + 1));
      col = texel_index_of(tu, longint'(TEX_W));
      row = texel_index_of(tv, longint'(TEX_H));
      // Fold the address into the store when the texture outgrows it.
      return ADDR_W'((row * TEX_W + col) & (STORE_DEPTH - 1));
   endfunction

   task automatic report_mismatch(string what, logic [TEXEL_W-1:0] got,
                                  logic [TEXEL_W-1:0] want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("cycle %0d: %s: got %h, want %h", cycle_count, what, got, want);
      end
      mismatch_count++;
   endtask

   // One process tracks register writes, accepted transactions and
   // responses, so the mirror is always updated in edge order: predict
   // first, then retire.
   always @(posedge clock) begin : texel_scoreboard
      logic [TEXEL_W-1:0] want;
      if (reset) begin
         shadow_cfg.coef_cos        = COEF_W'(1024);
         shadow_cfg.coef_sin        = '0;
         shadow_cfg.screen_center_x = '0;
         shadow_cfg.screen_center_y = '0;
         shadow_cfg.tex_center_x    = CENTER_W'(8);
         shadow_cfg.tex_center_y    = CENTER_W'(8);
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_COEF_COS:        shadow_cfg.coef_cos        = csr_wdata[COEF_W-1:0];
               CSR_COEF_SIN:        shadow_cfg.coef_sin        = csr_wdata[COEF_W-1:0];
               CSR_SCREEN_CENTER_X: shadow_cfg.screen_center_x = csr_wdata[PIX_W-1:0];
               CSR_SCREEN_CENTER_Y: shadow_cfg.screen_center_y = csr_wdata[PIX_W-1:0];
               CSR_TEX_CENTER_X:    shadow_cfg.tex_center_x    = csr_wdata[CENTER_W-1:0];
               CSR_TEX_CENTER_Y:    shadow_cfg.tex_center_y    = csr_wdata[CENTER_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_kind == KIND_WRITE) begin
               texture_mirror[req_texel_addr] = req_texel_value;
            end else begin
               pending_texels.push_back(
                  texture_mirror[render_addr_for(req_pixel_x, req_pixel_y)]);
            end
         end
         if (rsp_strobe) begin
            if (pending_texels.size() == 0) begin
               report_mismatch("texel with no render outstanding", rsp_texel_out, 'x);
            end else begin
               want = pending_texels.pop_front();
               if (rsp_texel_out !== want) begin
                  report_mismatch("texel_out", rsp_texel_out, want);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Issue one transaction. Call at a rising edge; returns at the edge that
   // accepted it, with start still high so back-to-back issue has no bubble.
   task automatic send_item(logic kind, logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                            logic [ADDR_W-1:0] addr, logic [TEXEL_W-1:0] value);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_kind        <= kind;
      req_pixel_x     <= px;
      req_pixel_y     <= py;
      req_texel_addr  <= addr;
      req_texel_value <= value;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // Drop start, wait for the last acceptance to be mirrored and for every owed
   // texel, then drain the pipeline since writes owe nothing.
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_texels.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Load all six registers while idle. Bits above a narrow register's width
   // carry noise: the block must ignore them.
   task automatic load_settings(int cos_v, int sin_v, int scx, int scy, int tcx, int tcy);
      logic [CSR_DATA_W-1:0] word;
      wait_idle();
      write_reg(CSR_COEF_COS, COEF_W'(cos_v));
      write_reg(CSR_COEF_SIN, COEF_W'(sin_v));
      word = CSR_DATA_W'($urandom);
      word[PIX_W-1:0] = PIX_W'(scx);
      write_reg(CSR_SCREEN_CENTER_X, word);
      word = CSR_DATA_W'($urandom);
      word[PIX_W-1:0] = PIX_W'(scy);
      write_reg(CSR_SCREEN_CENTER_Y, word);
      word = CSR_DATA_W'($urandom);
      word[CENTER_W-1:0] = CENTER_W'(tcx);
      write_reg(CSR_TEX_CENTER_X, word);
      word = CSR_DATA_W'($urandom);
      word[CENTER_W-1:0] = CENTER_W'(tcy);
      write_reg(CSR_TEX_CENTER_Y, word);
      csr_we <= 1'b0;
   endtask

   // Coefficients: realistic zoom levels, sometimes the register rails
   // or a full-range value.
   function automatic int rand_coef();
      case ($urandom_range(0, 4))
         0:       return -131072;
         1:       return 131071;
         2:       return int'($signed(COEF_W'($urandom)));
         default: return int'($urandom_range(0, 4095)) - 2048;
      endcase
   endfunction

   function automatic int rand_center(int top);
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return top;
         default: return int'($urandom_range(0, top));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Fill every texel first so no render can ever hit an unwritten entry.
   task automatic test_preload_texture();
      for (int i = 0; i < STORE_DEPTH; i++) begin
         send_item(KIND_WRITE, PIX_W'($urandom), PIX_W'($urandom), ADDR_W'(i),
                   TEXEL_W'($urandom));
      end
   endtask

   task automatic test_directed_corners();
      // Reset settings: pixel (0,0) lands on texel (8,8). Overwrite it and read
      // it back right behind each write, with the ignored fields at both rails.
      send_item(KIND_WRITE,  '1, '1, ADDR_W'(136), 8'hA5);
      send_item(KIND_RENDER, '0, '0, '1, '1);
      send_item(KIND_WRITE,  '0, '0, ADDR_W'(136), 8'h5A);
      send_item(KIND_RENDER, '0, '0, '0, '0);
      // Screen corners and the odd pixel that exercises the half-pixel step.
      send_item(KIND_RENDER, '1, '1, '0, '1);
      send_item(KIND_RENDER, '0, '1, '1, '0);
      send_item(KIND_RENDER, '1, '0, '0, '0);
      send_item(KIND_RENDER, PIX_W'(1), PIX_W'(1), '0, '0);
      send_item(KIND_WRITE,  '0, '0, '0, '0);
      send_item(KIND_WRITE,  '1, '1, '1, '1);

      // Rail coefficients, far-corner screen center: offsets go negative and
      // the coordinates must wrap through zero.
      load_settings(-131072, 131071, 2047, 2047, 255, 0);
      send_item(KIND_RENDER, '0, '0, '0, '0);
      send_item(KIND_RENDER, '1, '1, '0, '0);
      send_item(KIND_RENDER, '0, '1, '0, '0);
      send_item(KIND_RENDER, '1, '0, '0, '0);

      // Writes past the register list must change nothing.
      wait_idle();
      write_reg(CSR_SPARE_LO, '1);
      write_reg(CSR_SPARE_HI, '0);
      csr_we <= 1'b0;
      send_item(KIND_RENDER, '0, '0, '0, '0);
      send_item(KIND_RENDER, PIX_W'(1023), PIX_W'(1024), '0, '0);

      // Opposite rails.
      load_settings(131071, -131072, 0, 2047, 0, 255);
      send_item(KIND_RENDER, '1, '0, '0, '0);
      send_item(KIND_RENDER, '0, '1, '0, '0);

      // Zero coefficients collapse the whole screen onto the texture center.
      load_settings(0, 0, 1024, 1024, 128, 128);
      send_item(KIND_RENDER, PIX_W'(5), PIX_W'(7), '0, '0);
   endtask

   // Batches of mixed traffic, each under freshly drawn settings. Half the
   // renders stay near the screen center, where the mapping is dense.
   task automatic test_random_traffic(int idle_pct, int batches, int per_batch);
      int scx;
      int scy;
      sender_idle_pct = idle_pct;
      repeat (batches) begin
         scx = rand_center(2047);
         scy = rand_center(2047);
         load_settings(rand_coef(), rand_coef(), scx, scy, rand_center(255),
                       rand_center(255));
         repeat (per_batch) begin
            if ($urandom_range(0, 4) == 0) begin
               send_item(KIND_WRITE, PIX_W'($urandom), PIX_W'($urandom),
                         ADDR_W'($urandom), TEXEL_W'($urandom));
            end else if ($urandom_range(0, 1) == 0) begin
               send_item(KIND_RENDER, PIX_W'(scx + int'($urandom_range(0, 63)) - 32),
                         PIX_W'(scy + int'($urandom_range(0, 63)) - 32),
                         ADDR_W'($urandom), TEXEL_W'($urandom));
            end else begin
               send_item(KIND_RENDER, PIX_W'($urandom), PIX_W'($urandom),
                         ADDR_W'($urandom), TEXEL_W'($urandom));
            end
         end
      end
   endtask

   initial begin : regression
      int drain_cycles;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 8;
      test_preload_texture();
      test_directed_corners();
      // Light sender gaps, then heavy gaps, then back-to-back issue.
      test_random_traffic(8, 5, 92);
      test_random_traffic(78, 5, 92);
      test_random_traffic(0, 5, 92);

      // Wait out the last owed texels, with a bound, then flag leftovers.
      start <= 1'b0;
      @(posedge clock);
      drain_cycles = 0;
      while (pending_texels.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (PIPE_DRAIN) @(posedge clock);
      while (pending_texels.size() != 0) begin
         report_mismatch("render never answered", 'x, pending_texels.pop_front());
      end

      if (mismatch_count == 0) begin
         $display("affine_texture_sampler_unit regression: pass");
      end else begin
         $display("affine_texture_sampler_unit regression: fail");
      end
      $finish;
   end

endmodule
